FILE: sv/ecc_pkg.sv
// Shared types, constants and a helper function for the epoch seconds calendar clock.
package ecc_pkg;

	localparam int IN_W  = 32;
	localparam int OUT_W = 80;

	localparam logic [31:0] UTC_LIMIT         = 32'd4102444799;
	localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
	localparam logic [11:0] BASE_YEAR         = 12'd1968;

	// Divisors, used to form remainders from quotients.
	localparam logic [16:0] DIV_DAY_C  = 17'd86400;
	localparam logic [11:0] DIV_HOUR_C = 12'd3600;
	localparam logic [5:0]  DIV_MIN_C  = 6'd60;
	localparam logic [10:0] DIV_CYC_C  = 11'd1461;
	localparam logic [2:0]  DIV_WEEK_C = 3'd7;

	// Rounded-up reciprocals; each is exact over the dividend range it sees.
	// Day: (count >> 7) / 675, scaled by 2^35.
	localparam logic [25:0] RCP_DAY_C  = 26'd50903317;
	// Hour: (seconds of day >> 4) / 225, scaled by 2^21.
	localparam logic [13:0] RCP_HOUR_C = 14'd9321;
	// Minute: (seconds of hour >> 2) / 15, scaled by 2^14.
	localparam logic [10:0] RCP_MIN_C  = 11'd1093;
	// Four-year cycle: days / 1461, scaled by 2^27.
	localparam logic [16:0] RCP_CYC_C  = 17'd91868;
	// Week: days / 7, scaled by 2^19.
	localparam logic [16:0] RCP_WEEK_C = 17'd74899;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_DAY_QUOT,
		OP_DAY_REM,
		OP_HOUR_QUOT,
		OP_HOUR_REM,
		OP_MIN_QUOT,
		OP_MIN_REM,
		OP_YEAR_STEP,
		OP_MONTH_STEP,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} status_t;

	// February is long only in the first year of a four-year cycle.
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic first_year);
		logic [4:0] len;
		case (month)
			4'd2:    len = first_year ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: sv/ecc_ctrl.sv
// Sequencer for the calendar clock: handshakes and per-cycle datapath commands.
module ecc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  ecc_pkg::status_t status,
	output ecc_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DAYQ  = 4'd1;
	localparam logic [3:0] ST_DAYR  = 4'd2;
	localparam logic [3:0] ST_HOURQ = 4'd3;
	localparam logic [3:0] ST_HOURR = 4'd4;
	localparam logic [3:0] ST_MINQ  = 4'd5;
	localparam logic [3:0] ST_MINR  = 4'd6;
	localparam logic [3:0] ST_YEAR  = 4'd7;
	localparam logic [3:0] ST_MONTH = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       m_tvalid_q;
	logic       fin_fire;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign fin_fire = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d = state_q;
		cmd.op  = ecc_pkg::OP_IDLE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = ecc_pkg::OP_LOAD;
					state_d = ST_DAYQ;
				end
			end
			ST_DAYQ: begin
				cmd.op  = ecc_pkg::OP_DAY_QUOT;
				state_d = ST_DAYR;
			end
			ST_DAYR: begin
				cmd.op  = ecc_pkg::OP_DAY_REM;
				state_d = ST_HOURQ;
			end
			ST_HOURQ: begin
				cmd.op  = ecc_pkg::OP_HOUR_QUOT;
				state_d = ST_HOURR;
			end
			ST_HOURR: begin
				cmd.op  = ecc_pkg::OP_HOUR_REM;
				state_d = ST_MINQ;
			end
			ST_MINQ: begin
				cmd.op  = ecc_pkg::OP_MIN_QUOT;
				state_d = ST_MINR;
			end
			ST_MINR: begin
				cmd.op  = ecc_pkg::OP_MIN_REM;
				state_d = ST_YEAR;
			end
			ST_YEAR: begin
				if (status.year_done) state_d = ST_MONTH;
				else cmd.op = ecc_pkg::OP_YEAR_STEP;
			end
			ST_MONTH: begin
				if (status.month_done) state_d = ST_FIN;
				else cmd.op = ecc_pkg::OP_MONTH_STEP;
			end
			ST_FIN: begin
				// Hold until the output register is free.
				if (fin_fire) begin
					cmd.op  = ecc_pkg::OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_fire) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/ecc_dpath.sv
// Datapath: seconds counter, constant dividers, year and month walk, output register.
module ecc_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ecc_pkg::cmd_t              cmd,
	input  logic [ecc_pkg::IN_W-1:0]   in_data,
	output ecc_pkg::status_t           status,
	output logic [ecc_pkg::OUT_W-1:0]  out_data
);

	logic [31:0] count_q, count_n;
	logic [15:0] quot_q;
	logic [16:0] secs_q;
	logic [15:0] days_q;
	logic [2:0]  q7_q;
	logic [2:0]  wd_q;
	logic [5:0]  cyc_q;
	logic [11:0] rsec_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [11:0] year_q;
	logic [10:0] doy_q;
	logic [3:0]  month_q;
	logic        first_q;
	logic [5:0]  prev_second_q;
	logic [5:0]  prev_minute_q;
	logic [4:0]  prev_hour_q;
	logic [4:0]  prev_day_q;
	logic [ecc_pkg::OUT_W-1:0] out_q;

	logic [50:0] day_prod;
	logic [16:0] day_back;
	logic [16:0] secs_n;
	logic [21:0] week_prod;
	logic [2:0]  week_back;
	logic [25:0] hour_prod;
	logic [32:0] cyc_prod;
	logic [11:0] hour_back;
	logic [11:0] rsec_n;
	logic [10:0] cyc_back;
	logic [10:0] doy_n;
	logic [19:0] min_prod;
	logic [5:0]  min_back;
	logic [5:0]  second_n;
	logic [8:0]  ylen;
	logic [4:0]  mlen;
	logic [4:0]  day_n;
	logic [3:0]  wd_sum;
	logic [2:0]  wd_n;

	// Load saturates; a zero value advances by one second, clamped at the limit.
	always_comb begin
		if (in_data != 32'd0)
			count_n = (in_data > ecc_pkg::UTC_LIMIT) ? ecc_pkg::UTC_LIMIT : in_data;
		else if (count_q < ecc_pkg::UTC_LIMIT)
			count_n = count_q + 32'd1;
		else
			count_n = ecc_pkg::UTC_LIMIT;
	end

	// Quotients by reciprocal multiplication, remainders by multiply and subtract.
	assign day_prod  = 51'(count_q[31:7]) * 51'(ecc_pkg::RCP_DAY_C);
	assign day_back  = 17'(quot_q) * ecc_pkg::DIV_DAY_C;
	assign secs_n    = count_q[16:0] - day_back;
	assign week_prod = 22'(quot_q) * 22'(ecc_pkg::RCP_WEEK_C);
	assign week_back = q7_q * ecc_pkg::DIV_WEEK_C;
	assign hour_prod = 26'(secs_q[16:4]) * 26'(ecc_pkg::RCP_HOUR_C);
	assign cyc_prod  = 33'(days_q) * 33'(ecc_pkg::RCP_CYC_C);
	assign hour_back = 12'(hour_q) * ecc_pkg::DIV_HOUR_C;
	assign rsec_n    = secs_q[11:0] - hour_back;
	assign cyc_back  = 11'(cyc_q) * ecc_pkg::DIV_CYC_C;
	assign doy_n     = days_q[10:0] - cyc_back;
	assign min_prod  = 20'(rsec_q[11:2]) * 20'(ecc_pkg::RCP_MIN_C);
	assign min_back  = minute_q * ecc_pkg::DIV_MIN_C;
	assign second_n  = rsec_q[5:0] - min_back;

	assign ylen = first_q ? 9'd366 : 9'd365;
	assign mlen = ecc_pkg::month_len(month_q, first_q);
	assign status.year_done  = ({1'b0, doy_q} < {3'b0, ylen});
	assign status.month_done = (doy_q < {6'b0, mlen});

	assign day_n  = doy_q[4:0] + 5'd1;
	assign wd_sum = {1'b0, wd_q} + 4'd4;
	assign wd_n   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= 32'd0;
			prev_second_q <= 6'd0;
			prev_minute_q <= 6'd0;
			prev_hour_q   <= 5'd0;
			prev_day_q    <= 5'd1;
		end else begin
			if (cmd.op == ecc_pkg::OP_LOAD) count_q <= count_n;
			if (cmd.op == ecc_pkg::OP_FINISH) begin
				prev_second_q <= second_q;
				prev_minute_q <= minute_q;
				prev_hour_q   <= hour_q;
				prev_day_q    <= day_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ecc_pkg::OP_DAY_QUOT: begin
				quot_q <= day_prod[50:35];
			end
			ecc_pkg::OP_DAY_REM: begin
				secs_q <= secs_n;
				days_q <= quot_q + ecc_pkg::DAYS_1968_TO_1970;
				q7_q   <= week_prod[21:19];
			end
			ecc_pkg::OP_HOUR_QUOT: begin
				hour_q <= hour_prod[25:21];
				cyc_q  <= cyc_prod[32:27];
				// Days since 1970 mod 7.
				wd_q   <= quot_q[2:0] - week_back;
			end
			ecc_pkg::OP_HOUR_REM: begin
				rsec_q  <= rsec_n;
				year_q  <= ecc_pkg::BASE_YEAR + {4'b0, cyc_q, 2'b00};
				doy_q   <= doy_n;
				month_q <= 4'd1;
				first_q <= 1'b1;
			end
			ecc_pkg::OP_MIN_QUOT: begin
				minute_q <= min_prod[19:14];
			end
			ecc_pkg::OP_MIN_REM: begin
				second_q <= second_n;
			end
			ecc_pkg::OP_YEAR_STEP: begin
				doy_q   <= doy_q - {2'b0, ylen};
				year_q  <= year_q + 12'd1;
				first_q <= 1'b0;
			end
			ecc_pkg::OP_MONTH_STEP: begin
				doy_q   <= doy_q - {6'b0, mlen};
				month_q <= month_q + 4'd1;
			end
			ecc_pkg::OP_FINISH: begin
				out_q[31:0]  <= count_q;
				out_q[43:32] <= year_q;
				out_q[47:44] <= month_q;
				out_q[52:48] <= day_n;
				out_q[57:53] <= hour_q;
				out_q[63:58] <= minute_q;
				out_q[69:64] <= second_q;
				out_q[72:70] <= wd_n;
				out_q[73]    <= (second_q != prev_second_q);
				out_q[74]    <= (minute_q != prev_minute_q);
				out_q[75]    <= (hour_q != prev_hour_q);
				out_q[76]    <= (day_n != prev_day_q);
				out_q[79:77] <= 3'd0;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/epoch_seconds_calendar_clock_top.sv
// Top level of the epoch seconds calendar clock.
//
// Usage:
//   Slave channel s_*: one transfer per tick or load. A nonzero s_tdata loads
//   that count of seconds since 1970 (clamped to 2099-12-31 23:59:59); zero
//   advances the count by one second (held at the same limit).
//   Master channel m_*: one transfer per input transfer carrying the count,
//   the calendar date, the time of day, the weekday (0 = Sunday) and four
//   change flags against the previous result.
// Sequencing:
//   One item at a time. After the input transfer the sequencer runs the
//   quotient and remainder steps by reciprocal multiply (86400, 3600 and
//   60, with the four-year split and weekday alongside), then the year walk
//   and the month walk, then writes the output register. s_tready is high
//   only while the sequencer is idle, so a new input is not taken until the
//   previous result has been written to the output register.
// Reset (arst_n low): count goes to 0 and the previous-value registers to
//   day 1, 00:00:00; no result is pending.
// Stalls: a finished result is held in the output register while m_tready
//   is low; the next input is still accepted and computed, and its result
//   waits in the final step until the output register drains.
module epoch_seconds_calendar_clock_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// new_utc [31:0]
	input  logic [ecc_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// utc_now [31:0], year [43:32], month [47:44], day_of_month [52:48],
	// hour [57:53], minute [63:58], second [69:64], weekday [72:70],
	// second_changed [73], minute_changed [74], hour_changed [75],
	// day_changed [76], zero fill [79:77]
	output logic [ecc_pkg::OUT_W-1:0] m_tdata
);

	ecc_pkg::cmd_t    cmd;
	ecc_pkg::status_t status;

	// Sequencer: owns both handshakes and drives one datapath op per cycle.
	ecc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: counter, constant dividers, calendar walk and output register.
	ecc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_tdata),
		.status   (status),
		.out_data (m_tdata)
	);

endmodule
